/* sv/u8u16_pkg.sv */
// shared types and constants for the utf-8 to utf-16 offset mapper
package u8u16_pkg;

    localparam int CNT_W = 17;
    localparam int ACC_W = 21;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_TAG  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_TAG  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_TAG  = 8'hF0;
    localparam logic [7:0] ASCII_LIM  = 8'h80;
    localparam logic [7:0] PAY2_MASK  = 8'h1F;
    localparam logic [7:0] PAY3_MASK  = 8'h0F;
    localparam logic [7:0] PAY4_MASK  = 8'h07;
    localparam logic [7:0] CONT_MASK  = 8'h3F;
    localparam logic [ACC_W-1:0] BMP_MAX = 21'h00FFFF;

    localparam logic DIR_COUNT  = 1'b0;
    localparam logic DIR_OFFSET = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] byte_position;
        logic [CNT_W-1:0] sequence_start;
        logic [1:0]       bytes_pending;
        logic [ACC_W-1:0] code_point_acc;
        logic [CNT_W-1:0] unit_total;
        logic [CNT_W-1:0] held_target;
        logic             halted;
        logic             in_job;
    } job_state_t;

    typedef struct packed {
        logic [CNT_W-1:0] result_value;
        logic             cut_short;
    } result_t;

endpackage

/* sv/u8u16_ifs.sv */
// stream interfaces for input bytes and line results
interface u8u16_byte_if
    import u8u16_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [7:0]       data_byte;
    logic             has_byte;
    logic             last_byte;
    logic [CNT_W-1:0] unit_target;

    modport source (output valid, data_byte, has_byte, last_byte, unit_target, input ready);
    modport sink (input valid, data_byte, has_byte, last_byte, unit_target, output ready);
endinterface

interface u8u16_res_if
    import u8u16_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] result_value;
    logic             cut_short;

    modport source (output valid, result_value, cut_short, input ready);
    modport sink (input valid, result_value, cut_short, output ready);
endinterface

/* sv/u8u16_cfg.sv */
// apb-style configuration register holding the direction mode
module u8u16_cfg
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        direction
);

    logic direction_reg;
    logic direction_next;

    always_comb
    begin
        direction_next = direction_reg;
        if (psel && penable && pwrite && (paddr[2] == 1'b0))
        begin
            direction_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_COUNT;
        end
        else
        begin
            direction_reg <= direction_next;
        end
    end

    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == 1'b0) ? {31'd0, direction_reg} : 32'd0;
    assign direction = direction_reg;

endmodule

/* sv/u8u16_step.sv */
// per-byte decode and count update, one item per evaluation
module u8u16_step
    import u8u16_pkg::*;
#(
    parameter int MAX_LINE_BYTES = 65536
)
(
    input  job_state_t       cur,
    input  logic [7:0]       data_byte,
    input  logic             has_byte,
    input  logic             last_byte,
    input  logic [CNT_W-1:0] unit_target,
    input  logic             direction,
    output job_state_t       nxt,
    output logic             emit,
    output result_t          res
);

    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam int CAP_INT = (MAX_LINE_BYTES < CNT_MAX) ? MAX_LINE_BYTES : CNT_MAX;
    localparam logic [CNT_W:0] CNT_CAP = (CNT_W + 1)'(CAP_INT);

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W - 1){1'b0}}, b};
        return (s > CNT_CAP) ? CNT_CAP[CNT_W-1:0] : s[CNT_W-1:0];
    endfunction

    always_comb
    begin
        job_state_t      s;
        logic            fin;
        logic [1:0]      units;
        logic [CNT_W:0]  sum;
        logic [ACC_W-1:0] acc_sh;

        s = cur;
        fin = 1'b0;
        units = 2'd1;
        sum = '0;
        acc_sh = '0;

        // first item of a job clears the job and samples the target
        if (!cur.in_job)
        begin
            s = '0;
            s.held_target = unit_target;
            s.in_job = 1'b1;
        end

        if (has_byte)
        begin
            if (s.bytes_pending == 2'd0)
            begin
                if (!s.halted && (s.unit_total >= s.held_target))
                begin
                    s.halted = 1'b1;
                end
                if (!s.halted)
                begin
                    s.sequence_start = s.byte_position;
                end
                if (data_byte < ASCII_LIM)
                begin
                    fin = 1'b1;
                end
                else if ((data_byte & LEAD2_MASK) == LEAD2_TAG)
                begin
                    s.code_point_acc = {13'd0, data_byte & PAY2_MASK};
                    s.bytes_pending = 2'd1;
                end
                else if ((data_byte & LEAD3_MASK) == LEAD3_TAG)
                begin
                    s.code_point_acc = {13'd0, data_byte & PAY3_MASK};
                    s.bytes_pending = 2'd2;
                end
                else if ((data_byte & LEAD4_MASK) == LEAD4_TAG)
                begin
                    s.code_point_acc = {13'd0, data_byte & PAY4_MASK};
                    s.bytes_pending = 2'd3;
                end
                else
                begin
                    // invalid lead counts as one replacement unit
                    fin = 1'b1;
                end
            end
            else
            begin
                acc_sh = {s.code_point_acc[ACC_W-7:0], 6'd0};
                s.code_point_acc = acc_sh | {13'd0, data_byte & CONT_MASK};
                s.bytes_pending = s.bytes_pending - 2'd1;
                if (s.bytes_pending == 2'd0)
                begin
                    fin = 1'b1;
                    units = (s.code_point_acc > BMP_MAX) ? 2'd2 : 2'd1;
                end
            end

            if (fin)
            begin
                sum = {1'b0, s.unit_total} + {{(CNT_W - 1){1'b0}}, units};
                if (!s.halted && (sum > {1'b0, s.held_target}))
                begin
                    s.halted = 1'b1;
                end
                s.unit_total = sat_add(s.unit_total, units);
            end
            s.byte_position = sat_add(s.byte_position, 2'd1);
        end

        emit = last_byte;
        res.result_value = s.byte_position;
        res.cut_short = 1'b0;
        if (direction == DIR_COUNT)
        begin
            res.result_value = s.unit_total;
            res.cut_short = (s.bytes_pending != 2'd0);
        end
        else if (s.halted)
        begin
            res.result_value = s.sequence_start;
        end
        else if (s.bytes_pending != 2'd0)
        begin
            res.result_value = s.sequence_start;
            res.cut_short = 1'b1;
        end

        if (last_byte)
        begin
            s.in_job = 1'b0;
        end
        nxt = s;
    end

endmodule

/* sv/utf8_utf16_offset_mapper.sv */
// top level of the utf-8 line to utf-16 offset mapper
//
//  channel   dir  beat                                          accepted when
//  bytes     in   data_byte, has_byte, last_byte, unit_target   valid && ready
//  results   out  result_value, cut_short                       valid && ready
//  apb       in   direction register at byte address 0          psel && penable && pwrite
//
// one byte beat per cycle sustained while no closing beat is stalled; a byte is
// registered in the input stage, where the decode and counters update, and its
// result is then registered in the output register, which drives result valid.
// rst_n clears the stage valid, the job state and the output valid; the
// direction register resets to count mode.
// a result waiting in the output register only stalls the input stage when the
// staged beat also closes a line; other beats keep flowing.
module utf8_utf16_offset_mapper
    import u8u16_pkg::*;
#(
    parameter int MAX_LINE_BYTES = 65536
)
(
    input  logic         clk,
    input  logic         rst_n,
    u8u16_byte_if.sink   bytes,
    u8u16_res_if.source  results,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // input stage
    logic             stg_valid_reg;
    logic [7:0]       stg_byte_reg;
    logic             stg_has_reg;
    logic             stg_last_reg;
    logic [CNT_W-1:0] stg_target_reg;

    // job state carried across beats of a line
    job_state_t       state_reg;
    job_state_t       state_next;

    // output register
    logic             out_valid_reg;
    result_t          out_reg;

    logic             direction;
    logic             emit;
    result_t          res;
    logic             advance;
    logic             take_in;

    u8u16_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .direction (direction)
    );

    u8u16_step #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_step (
        .cur         (state_reg),
        .data_byte   (stg_byte_reg),
        .has_byte    (stg_has_reg),
        .last_byte   (stg_last_reg),
        .unit_target (stg_target_reg),
        .direction   (direction),
        .nxt         (state_next),
        .emit        (emit),
        .res         (res)
    );

    // staged beat moves on unless it closes a line while the output slot is full and not being read
    assign advance = stg_valid_reg && (!emit || !out_valid_reg || results.ready);
    assign bytes.ready = !stg_valid_reg || advance;
    assign take_in = bytes.valid && bytes.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_in)
            begin
                stg_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stg_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                state_reg <= state_next;
            end

            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            stg_byte_reg   <= bytes.data_byte;
            stg_has_reg    <= bytes.has_byte;
            stg_last_reg   <= bytes.last_byte;
            stg_target_reg <= bytes.unit_target;
        end
        if (advance && emit)
        begin
            out_reg <= res;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.result_value = out_reg.result_value;
    assign results.cut_short    = out_reg.cut_short;

endmodule

/* tb/utf8_utf16_offset_mapper_tb.sv */
// self-checking testbench for the utf-8 to utf-16 offset mapper
`timescale 1ns / 1ps

module utf8_utf16_offset_mapper_tb;
    import u8u16_pkg::*;

    localparam int MAX_LINE_BYTES = 65536;
    // byte and unit counters stop at the line limit, never past the 17-bit range
    localparam int unsigned LINE_CAP = (MAX_LINE_BYTES < 131071) ? MAX_LINE_BYTES : 131071;
    localparam logic [ACC_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [2:0] REG_DIRECTION = 3'd0;
    localparam logic [CNT_W-1:0] TARGET_ALL_ONES = 17'h1FFFF;
    localparam int SETTLE_CYCLES = 4;      // result lags its last beat by the input and output registers
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT = 10;

    // one input beat as queued for the driver
    typedef struct packed {
        logic [7:0]       data_byte;
        logic             has_byte;
        logic             last_byte;
        logic [CNT_W-1:0] unit_target;
        logic             drain_first;   // hold this beat until all results are back
    } byte_beat_t;

    // decoder state of the line being walked
    typedef struct packed {
        logic [CNT_W-1:0] pos;
        logic [CNT_W-1:0] seq_start;
        logic [1:0]       pending;
        logic [ACC_W-1:0] cp;
        logic [CNT_W-1:0] units;
        logic [CNT_W-1:0] target;
        logic             halted;
        logic             active;
    } line_walk_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    u8u16_byte_if bytes_if ();
    u8u16_res_if  results_if ();

    utf8_utf16_offset_mapper #(.MAX_LINE_BYTES(MAX_LINE_BYTES)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes_if),
        .results (results_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 clk = ~clk;

    byte_beat_t  byte_beats[$];     // beats waiting for the driver
    result_t     line_results[$];   // expected line results, oldest first
    logic [7:0]  line_bytes[$];     // scratch for building one line
    line_walk_t  walk;
    logic        dir_setting;       // mirror of the direction register
    byte_beat_t  next_beat;
    logic        beat_taken;
    int unsigned send_idle_pct;
    int unsigned stall_pct;
    int unsigned mismatches;
    int unsigned quiet_cycles;
    result_t     want;

    // ------------------------------------------------------------------
    // line predictor
    // ------------------------------------------------------------------

    function automatic logic [CNT_W-1:0] cap_add(input logic [CNT_W-1:0] a, input int unsigned n);
        int unsigned s;
        s = a + n;
        if (s > LINE_CAP)
            s = LINE_CAP;
        return s[CNT_W-1:0];
    endfunction

    // a finished code point is worth one unit, or two above the bmp;
    // crossing the target marks the stop but counting goes on
    function automatic void close_code_point(input logic [ACC_W-1:0] cp);
        int unsigned n;
        int unsigned sum;
        n = (cp > BMP_MAX) ? 2 : 1;
        sum = walk.units + n;
        if (!walk.halted && sum > walk.target)
            walk.halted = 1'b1;
        walk.units = cap_add(walk.units, n);
    endfunction

    function automatic void take_line_byte(input logic [7:0] c);
        if (walk.pending == 2'd0)
        begin
            // start of a code point: stop here if the target is already met
            if (!walk.halted && walk.units >= walk.target)
                walk.halted = 1'b1;
            if (!walk.halted)
                walk.seq_start = walk.pos;
            if (c < ASCII_LIM)
                close_code_point({13'b0, c});
            else if ((c & LEAD2_MASK) == LEAD2_TAG)
            begin
                walk.cp = {13'b0, c & PAY2_MASK};
                walk.pending = 2'd1;
            end
            else if ((c & LEAD3_MASK) == LEAD3_TAG)
            begin
                walk.cp = {13'b0, c & PAY3_MASK};
                walk.pending = 2'd2;
            end
            else if ((c & LEAD4_MASK) == LEAD4_TAG)
            begin
                walk.cp = {13'b0, c & PAY4_MASK};
                walk.pending = 2'd3;
            end
            else
                close_code_point(REPLACEMENT_CP);   // stray continuation or bad lead
        end
        else
        begin
            // continuation tag is not checked, only the low six bits count
            walk.cp = {walk.cp[ACC_W-7:0], c[5:0]};
            walk.pending = walk.pending - 2'd1;
            if (walk.pending == 2'd0)
                close_code_point(walk.cp);
        end
        walk.pos = cap_add(walk.pos, 1);
    endfunction

    // one accepted beat; a closing beat queues its line result
    function automatic void map_byte_beat(input logic [7:0] c, input logic has, input logic last,
                                          input logic [CNT_W-1:0] tgt);
        result_t r;
        if (!walk.active)
        begin
            walk = '0;
            walk.target = tgt;
            walk.active = 1'b1;
        end
        if (has)
            take_line_byte(c);
        if (last)
        begin
            r.cut_short = 1'b0;
            if (dir_setting == DIR_COUNT)
            begin
                r.result_value = walk.units;
                r.cut_short = (walk.pending != 2'd0);
            end
            else if (walk.halted)
                r.result_value = walk.seq_start;
            else if (walk.pending != 2'd0)
            begin
                // line ended inside a sequence before any stop
                r.result_value = walk.seq_start;
                r.cut_short = 1'b1;
            end
            else
                r.result_value = walk.pos;
            line_results.push_back(r);
            walk.active = 1'b0;
        end
    endfunction

    function automatic void log_mismatch(input string what, input logic [31:0] exp_val,
                                         input logic [31:0] got_val);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t mismatch on %s: expected %0h, got %0h", $time, what, exp_val, got_val);
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------

    function automatic void push_beat(input logic [7:0] c, input logic has, input logic last,
                                      input logic [CNT_W-1:0] tgt, input logic drain);
        byte_beat_t b;
        b.data_byte = c;
        b.has_byte = has;
        b.last_byte = last;
        b.unit_target = tgt;
        b.drain_first = drain;
        byte_beats.push_back(b);
    endfunction

    // lead of a 2..4 byte sequence with random payload, then conts continuation bytes
    function automatic void add_sequence(input int unsigned len, input int unsigned conts);
        logic [31:0] r;
        int unsigned i;
        r = $urandom;
        case (len)
            2: line_bytes.push_back(LEAD2_TAG | {3'b0, r[4:0]});
            3: line_bytes.push_back(LEAD3_TAG | {4'b0, r[3:0]});
            default: line_bytes.push_back(LEAD4_TAG | {5'b0, r[2:0]});
        endcase
        for (i = 0; i < conts; i++)
        begin
            r = $urandom;
            // mostly proper 10xxxxxx tags, now and then any byte at all
            if (r[31:28] == 4'd0)
                line_bytes.push_back(r[7:0]);
            else
                line_bytes.push_back({2'b10, r[5:0]});
        end
    endfunction

    // turn line_bytes into beats; noisy lines get empty beats and odd endings
    function automatic void emit_line(input logic [CNT_W-1:0] tgt, input bit noisy);
        int unsigned i;
        bit first;
        bit tail_empty;
        bit drain;
        first = 1'b1;
        drain = noisy && ($urandom_range(19) == 0);
        tail_empty = (line_bytes.size() == 0) || (noisy && $urandom_range(9) == 0);
        if (noisy && $urandom_range(9) == 0)
        begin
            // an empty beat opens the line and carries the target
            push_beat(8'($urandom_range(255)), 1'b0, 1'b0, tgt, drain);
            first = 1'b0;
        end
        for (i = 0; i < line_bytes.size(); i++)
        begin
            if (noisy && !first && $urandom_range(99) < 8)
                push_beat(8'($urandom_range(255)), 1'b0, 1'b0,
                          CNT_W'($urandom_range(TARGET_ALL_ONES)), 1'b0);
            // later beats carry junk targets, only the opening one is sampled
            push_beat(line_bytes[i], 1'b1, !tail_empty && (i == line_bytes.size() - 1),
                      first ? tgt : CNT_W'($urandom_range(TARGET_ALL_ONES)), first && drain);
            first = 1'b0;
        end
        if (tail_empty)
            push_beat(8'($urandom_range(255)), 1'b0, 1'b1,
                      first ? tgt : CNT_W'($urandom_range(TARGET_ALL_ONES)), first && drain);
    endfunction

    function automatic void queue_line(input int unsigned max_chars);
        int unsigned n_seq;
        int unsigned i;
        int unsigned kind;
        int unsigned len;
        logic [31:0] r;
        logic [CNT_W-1:0] tgt;
        line_bytes.delete();
        n_seq = $urandom_range(max_chars);
        for (i = 0; i < n_seq; i++)
        begin
            kind = $urandom_range(99);
            r = $urandom;
            if (kind < 35)
                line_bytes.push_back({1'b0, r[6:0]});
            else if (kind < 50)
                add_sequence(2, 1);
            else if (kind < 65)
                add_sequence(3, 2);
            else if (kind < 80)
                add_sequence(4, 3);
            else if (kind < 90)
                // continuation used as a lead, or an 0xf8..0xff lead
                line_bytes.push_back(r[8] ? {2'b10, r[5:0]} : {5'b11111, r[2:0]});
            else
                line_bytes.push_back(r[7:0]);
        end
        // now and then the line stops inside a sequence
        if ($urandom_range(99) < 15)
        begin
            len = $urandom_range(4, 2);
            add_sequence(len, $urandom_range(len - 2));
        end
        kind = $urandom_range(99);
        if (kind < 75)
            tgt = CNT_W'($urandom_range(line_bytes.size() + 2));
        else if (kind < 85)
            tgt = CNT_W'($urandom_range(TARGET_ALL_ONES));
        else if (kind < 92)
            tgt = '0;
        else
            tgt = $urandom_range(1) ? 17'h10000 : TARGET_ALL_ONES;
        emit_line(tgt, 1'b1);
    endfunction

    function automatic void queue_random_lines(input int unsigned n_beats);
        int unsigned goal;
        goal = byte_beats.size() + n_beats;
        while (byte_beats.size() < goal)
            queue_line(12);
    endfunction

    // ------------------------------------------------------------------
    // apb and phase control
    // ------------------------------------------------------------------

    task automatic write_direction(input logic value);
        logic [31:0] rd;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_DIRECTION;
        pwdata <= {31'b0, value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        dir_setting = value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        // read back what was just written
        @(negedge clk);
        psel <= 1'b1;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        if (rd !== {31'b0, value})
            log_mismatch("direction readback", {31'b0, value}, rd);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // every beat sent, every result back, then let the pipe empty
    task automatic wait_idle();
        do
            @(posedge clk);
        while (byte_beats.size() != 0 || bytes_if.valid || line_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic dir, input int unsigned idle, input int unsigned stall,
                             input int unsigned n_beats);
        send_idle_pct = idle;
        stall_pct = stall;
        write_direction(dir);
        queue_random_lines(n_beats);
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // driver: new beats go out at the falling edge
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!bytes_if.valid || beat_taken)
            begin
                // a drain beat holds back until every line result has come
                if (byte_beats.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                    !(byte_beats[0].drain_first && line_results.size() != 0))
                begin
                    next_beat = byte_beats.pop_front();
                    bytes_if.valid <= 1'b1;
                    bytes_if.data_byte <= next_beat.data_byte;
                    bytes_if.has_byte <= next_beat.has_byte;
                    bytes_if.last_byte <= next_beat.last_byte;
                    bytes_if.unit_target <= next_beat.unit_target;
                end
                else
                    bytes_if.valid <= 1'b0;
            end
        end
        results_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // monitor: predict on each byte beat, check each result beat
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            beat_taken <= bytes_if.valid && bytes_if.ready;
            if (bytes_if.valid && bytes_if.ready)
                map_byte_beat(bytes_if.data_byte, bytes_if.has_byte, bytes_if.last_byte,
                              bytes_if.unit_target);
            if (results_if.valid && results_if.ready)
            begin
                if (line_results.size() == 0)
                    log_mismatch("result with none expected", 32'h0,
                                 {15'b0, results_if.result_value});
                else
                begin
                    want = line_results.pop_front();
                    if (results_if.result_value !== want.result_value)
                        log_mismatch("result_value", {15'b0, want.result_value},
                                     {15'b0, results_if.result_value});
                    if (results_if.cut_short !== want.cut_short)
                        log_mismatch("cut_short", {31'b0, want.cut_short},
                                     {31'b0, results_if.cut_short});
                end
            end
            // watchdog: any beat on any port counts as progress
            if ((bytes_if.valid && bytes_if.ready) || (results_if.valid && results_if.ready) ||
                (psel && penable && pready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         quiet_cycles, line_results.size());
                $display("** utf8_utf16_offset_mapper: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = REG_DIRECTION;
        pwdata = '0;
        bytes_if.valid = 1'b0;
        bytes_if.data_byte = '0;
        bytes_if.has_byte = 1'b0;
        bytes_if.last_byte = 1'b0;
        bytes_if.unit_target = '0;
        results_if.ready = 1'b1;
        beat_taken = 1'b0;
        walk = '0;
        dir_setting = DIR_COUNT;
        send_idle_pct = 0;
        stall_pct = 0;
        mismatches = 0;
        quiet_cycles = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // count mode: empty line, byte extremes with every sequence length,
        // invalid leads, then a line cut inside a sequence
        write_direction(DIR_COUNT);
        line_bytes.delete();
        emit_line('0, 1'b0);
        line_bytes = '{8'h00, 8'h7F, 8'hC3, 8'hA9, 8'hEF, 8'hBF, 8'hBF,
                       8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hFF, 8'h80};
        emit_line('0, 1'b0);
        line_bytes = '{8'hE2, 8'h82};
        emit_line('0, 1'b0);
        wait_idle();

        // offset mode: zero target stops at once, a surrogate pair overshoots
        // the target, an unreachable target with a cut-off tail
        write_direction(DIR_OFFSET);
        line_bytes = '{8'h41, 8'h42};
        emit_line('0, 1'b0);
        line_bytes = '{8'h41, 8'hF0, 8'h9F, 8'h98, 8'h80};
        emit_line(17'd2, 1'b0);
        line_bytes = '{8'h41, 8'hE2, 8'h82};
        emit_line(TARGET_ALL_ONES, 1'b0);
        wait_idle();

        // random lines across both modes and all idle patterns
        run_phase(DIR_OFFSET, 0, 0, 145);
        run_phase(DIR_COUNT, 65, 0, 145);
        run_phase(DIR_OFFSET, 0, 65, 145);
        run_phase(DIR_COUNT, 25, 25, 145);
        run_phase(DIR_OFFSET, 25, 25, 145);
        run_phase(DIR_COUNT, 0, 0, 145);

        if (mismatches == 0 && line_results.size() == 0)
            $display("** utf8_utf16_offset_mapper: PASSED **");
        else
            $display("** utf8_utf16_offset_mapper: FAILED **");
        $finish;
    end

endmodule
